/* rtl/core/rgbe_lightmap_atlas_blit_top_defines.svh */
// Assertion macros shared by the lightmap atlas blit checker.
`ifndef RGBE_LIGHTMAP_ATLAS_BLIT_TOP_DEFINES_SVH
`define RGBE_LIGHTMAP_ATLAS_BLIT_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RLAB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rlab: assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define RLAB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rlab: assertion failed");

`endif

/* rtl/core/rlab_pkg.sv */
// Types, constants and color functions of the lightmap atlas blit.
`timescale 1ns / 1ps
package rlab_pkg;

  typedef logic [7:0]        color_t;
  typedef logic signed [7:0] expo_t;
  typedef logic [10:0]       origin_t;
  typedef logic [11:0]       side_t;
  typedef logic [12:0]       coord_t;
  typedef logic [21:0]       addr_t;
  typedef logic [15:0]       pixel_t;
  typedef logic [7:0]        cfg_index_t;
  typedef logic [11:0]       cfg_data_t;

  // Register indexes of the configuration port.
  localparam cfg_index_t CFG_ATLAS_WIDTH  = 8'd0;
  localparam cfg_index_t CFG_ATLAS_HEIGHT = 8'd1;

  localparam side_t  RESET_ATLAS_SIDE = 12'd16;
  localparam color_t SAT_MAX          = 8'hFF;

  // Word held between the placement stage and the address stage.
  typedef struct packed {
    coord_t x;
    coord_t y;
    pixel_t pixel;
    logic   last;
    logic   oob;
  } stage_t;

  // Shift a mantissa by the signed shared exponent and saturate at 255.
  function automatic color_t scale_color(color_t m, expo_t e);
    logic [14:0] sh;
    expo_t       neg;
    color_t      res;
    sh  = '0;
    neg = -e;
    res = '0;
    if (!e[7]) begin
      if (m == '0) begin
        res = '0;
      end else if (e >= 8'sd8) begin
        res = SAT_MAX;
      end else begin
        sh  = {7'd0, m} << e[2:0];
        res = (sh > 15'd255) ? SAT_MAX : sh[7:0];
      end
    end else begin
      if (e <= -8'sd8) begin
        res = '0;
      end else begin
        res = m >> neg[2:0];
      end
    end
    return res;
  endfunction

  // Pack three scaled colors as RGB565, red on top.
  function automatic pixel_t pack_rgb565(color_t r, color_t g, color_t b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

/* rtl/core/rlab_if.sv */
// Channel interfaces of the lightmap atlas blit: samples, texels, configuration.
`timescale 1ns / 1ps
interface rlab_in_if;
  logic              valid;
  logic              ready;
  rlab_pkg::color_t  red;
  rlab_pkg::color_t  green;
  rlab_pkg::color_t  blue;
  rlab_pkg::expo_t   exponent;
  logic              face_start;
  rlab_pkg::origin_t origin_x;
  rlab_pkg::origin_t origin_y;
  rlab_pkg::side_t   face_width;
  rlab_pkg::side_t   face_height;

  modport source (output valid, red, green, blue, exponent, face_start,
                  origin_x, origin_y, face_width, face_height, input ready);
  modport sink   (input valid, red, green, blue, exponent, face_start,
                  origin_x, origin_y, face_width, face_height, output ready);
endinterface

interface rlab_out_if;
  logic             valid;
  logic             ready;
  rlab_pkg::addr_t  address;
  rlab_pkg::pixel_t pixel;
  logic             last_of_face;
  logic             out_of_bounds;

  modport source (output valid, address, pixel, last_of_face, out_of_bounds,
                  input ready);
  modport sink   (input valid, address, pixel, last_of_face, out_of_bounds,
                  output ready);
endinterface

interface rlab_cfg_if;
  logic                 valid;
  logic                 ready;
  rlab_pkg::cfg_index_t index;
  rlab_pkg::cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/rgbe_lightmap_atlas_blit_top.sv */
// Top level of the lightmap atlas blit: RGBE to RGB565 with atlas addressing.
`timescale 1ns / 1ps
// A sample word accepted at the input passes through stage A and then the output
// register. Throughput: one word per cycle when the output is not stalled; the
// face counters update in the accept cycle, and the row-times-pitch multiply has
// a stage of its own.
// Reset (rst_n low, synchronous) empties both stages, sets the atlas to 16 by 16
// and the current face to 1 by 1 at origin 0; configuration is always ready.
module rgbe_lightmap_atlas_blit_top #(
  parameter int MAX_ATLAS_SIDE = 2048
) (
  input logic        clk,
  input logic        rst_n,
  rlab_in_if.sink    in_ch,
  rlab_out_if.source out_ch,
  rlab_cfg_if.sink   cfg_ch
);

  // Sizes live in 12-bit fields, so the cap never exceeds what they can hold.
  localparam int SIDE_CAP = (MAX_ATLAS_SIDE > 4095) ? 4095 : MAX_ATLAS_SIDE;
  localparam rlab_pkg::side_t SIDE_CAP_W = 12'(SIDE_CAP);

  // Configuration registers. Writes must arrive only while the pipeline is idle (the block does not enforce this).
  rlab_pkg::side_t atlas_width_r, atlas_height_r;

  // Face walk state.
  rlab_pkg::side_t   column_r, row_r;
  rlab_pkg::origin_t base_x_r, base_y_r;
  rlab_pkg::side_t   cur_width_r, cur_height_r;

  rlab_pkg::side_t   column_nxt, row_nxt;
  rlab_pkg::origin_t base_x_nxt, base_y_nxt;
  rlab_pkg::side_t   cur_width_nxt, cur_height_nxt;

  // Pipeline stages.
  logic             a_valid_r;
  rlab_pkg::stage_t a_r, a_nxt;
  logic             out_valid_r;
  rlab_pkg::addr_t  address_r;
  rlab_pkg::pixel_t pixel_r;
  logic             last_r, oob_r;

  logic            in_fire, a_adv;
  rlab_pkg::side_t aw, ah;
  rlab_pkg::side_t face_w_clamped, face_h_clamped;
  rlab_pkg::coord_t col_inc, row_inc;
  logic [24:0]     addr_full;

  assign cfg_ch.ready = 1'b1;

  // Stage A moves on when the output register is empty or being emptied.
  assign a_adv       = a_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !a_valid_r || a_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign aw = (atlas_width_r  > SIDE_CAP_W) ? SIDE_CAP_W : atlas_width_r;
  assign ah = (atlas_height_r > SIDE_CAP_W) ? SIDE_CAP_W : atlas_height_r;

  // A zero face size counts as one, an oversized one is capped.
  assign face_w_clamped = (in_ch.face_width == '0) ? 12'd1 :
                          (in_ch.face_width > SIDE_CAP_W) ? SIDE_CAP_W : in_ch.face_width;
  assign face_h_clamped = (in_ch.face_height == '0) ? 12'd1 :
                          (in_ch.face_height > SIDE_CAP_W) ? SIDE_CAP_W : in_ch.face_height;

  // Placement of the current sample: a face start replaces the face at once,
  // and that sample is the first one of the new face.
  always_comb begin
    rlab_pkg::side_t col_eff, row_eff;
    rlab_pkg::color_t r_s, g_s, b_s;
    if (in_ch.face_start) begin
      base_x_nxt     = in_ch.origin_x;
      base_y_nxt     = in_ch.origin_y;
      cur_width_nxt  = face_w_clamped;
      cur_height_nxt = face_h_clamped;
      col_eff        = '0;
      row_eff        = '0;
    end else begin
      base_x_nxt     = base_x_r;
      base_y_nxt     = base_y_r;
      cur_width_nxt  = cur_width_r;
      cur_height_nxt = cur_height_r;
      col_eff        = column_r;
      row_eff        = row_r;
    end

    col_inc = {1'b0, col_eff} + 13'd1;
    row_inc = {1'b0, row_eff} + 13'd1;

    // Walk the face row by row, wrapping back to its origin after the end.
    if (col_inc >= {1'b0, cur_width_nxt}) begin
      column_nxt = '0;
      row_nxt    = (row_inc >= {1'b0, cur_height_nxt}) ? 12'd0 : row_inc[11:0];
    end else begin
      column_nxt = col_inc[11:0];
      row_nxt    = row_eff;
    end

    r_s = rlab_pkg::scale_color(in_ch.red,   in_ch.exponent);
    g_s = rlab_pkg::scale_color(in_ch.green, in_ch.exponent);
    b_s = rlab_pkg::scale_color(in_ch.blue,  in_ch.exponent);

    a_nxt.x     = {2'b00, base_x_nxt} + {1'b0, col_eff};
    a_nxt.y     = {2'b00, base_y_nxt} + {1'b0, row_eff};
    a_nxt.pixel = rlab_pkg::pack_rgb565(r_s, g_s, b_s);
    a_nxt.last  = (col_inc == {1'b0, cur_width_nxt}) &&
                  (row_inc == {1'b0, cur_height_nxt});
    a_nxt.oob   = (({2'b00, base_x_nxt} + {1'b0, cur_width_nxt})  > {1'b0, aw}) ||
                  (({2'b00, base_y_nxt} + {1'b0, cur_height_nxt}) > {1'b0, ah});
  end

  // Row times pitch plus column, kept to the 22-bit word index.
  assign addr_full = ({12'd0, a_r.y} * {13'd0, aw}) + {12'd0, a_r.x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_width_r  <= rlab_pkg::RESET_ATLAS_SIDE;
      atlas_height_r <= rlab_pkg::RESET_ATLAS_SIDE;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        rlab_pkg::CFG_ATLAS_WIDTH:  atlas_width_r  <= cfg_ch.data;
        rlab_pkg::CFG_ATLAS_HEIGHT: atlas_height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      row_r        <= '0;
      base_x_r     <= '0;
      base_y_r     <= '0;
      cur_width_r  <= 12'd1;
      cur_height_r <= 12'd1;
    end else if (in_fire) begin
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      base_x_r     <= base_x_nxt;
      base_y_r     <= base_y_nxt;
      cur_width_r  <= cur_width_nxt;
      cur_height_r <= cur_height_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; the valid flags above qualify them.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_r <= a_nxt;
    end
    if (a_adv) begin
      address_r <= addr_full[21:0];
      pixel_r   <= a_r.pixel;
      last_r    <= a_r.last;
      oob_r     <= a_r.oob;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.address       = address_r;
  assign out_ch.pixel         = pixel_r;
  assign out_ch.last_of_face  = last_r;
  assign out_ch.out_of_bounds = oob_r;

endmodule

/* rtl/core/rlab_checker.sv */
// Port-level assertions of the lightmap atlas blit and their bind.
`timescale 1ns / 1ps
`include "rgbe_lightmap_atlas_blit_top_defines.svh"
module rlab_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input rlab_pkg::addr_t  out_address,
  input rlab_pkg::pixel_t out_pixel,
  input logic             out_last,
  input logic             out_oob
);

  logic        out_stalled;
  logic [39:0] out_word;

  assign out_stalled = out_valid && !out_ready;
  assign out_word    = {out_address, out_pixel, out_last, out_oob};

  // The output word is empty in the cycle after a reset edge.
  `RLAB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // Input backpressure only comes from a stalled, full output register.
  `RLAB_ASSERT(a_stall_source, clk, rst_n, !in_ready |-> out_stalled)

  // A stalled output word stays offered.
  `RLAB_ASSERT(a_hold_valid, clk, rst_n, out_stalled |=> out_valid)

  // A stalled output word keeps its contents.
  `RLAB_ASSERT(a_hold_word, clk, rst_n, out_stalled |=> $stable(out_word))

endmodule

bind rgbe_lightmap_atlas_blit_top rlab_checker u_rlab_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_address (out_ch.address),
  .out_pixel   (out_ch.pixel),
  .out_last    (out_ch.last_of_face),
  .out_oob     (out_ch.out_of_bounds)
);

/* dv/rgbe_lightmap_atlas_blit_top_tb.sv */
// Self-checking testbench of the lightmap atlas blit: RGBE samples in, RGB565 atlas texels out.
`timescale 1ns / 1ps
module rgbe_lightmap_atlas_blit_top_tb;

  localparam int MAX_SIDE         = 2048;
  localparam int CYCLE_LIMIT      = 400000;
  // Two pipeline stages, plus margin, before the block counts as idle.
  localparam int SETTLE_CYCLES    = 6;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int WORDS_PER_PHASE  = 70;
  localparam int NUM_PHASES       = 7;

  // One sample word as the sender presents it.
  typedef struct {
    rlab_pkg::color_t  red;
    rlab_pkg::color_t  green;
    rlab_pkg::color_t  blue;
    rlab_pkg::expo_t   exponent;
    logic              face_start;
    rlab_pkg::origin_t origin_x;
    rlab_pkg::origin_t origin_y;
    rlab_pkg::side_t   face_width;
    rlab_pkg::side_t   face_height;
  } sample_t;

  // One texel word as the block returns it.
  typedef struct {
    rlab_pkg::addr_t  address;
    rlab_pkg::pixel_t pixel;
    logic             last_of_face;
    logic             out_of_bounds;
  } texel_t;

  // A directed word, with its texel typed in when it is obvious by inspection.
  typedef struct {
    sample_t smp;
    bit      typed;
    texel_t  want;
  } directed_row_t;

  // Ready patterns that the texel receiver cycles through.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_PATTERN,
    READY_SPARSE
  } ready_mode_t;

  logic clk;
  logic rst_n;

  rlab_in_if  in_ch ();
  rlab_out_if out_ch ();
  rlab_cfg_if cfg_ch ();

  rgbe_lightmap_atlas_blit_top #(
    .MAX_ATLAS_SIDE(MAX_SIDE)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Shadow copy of the atlas registers and the face walk; the walk advances once per
  // accepted sample word.
  int unsigned atlas_w_reg = 16;
  int unsigned atlas_h_reg = 16;
  int unsigned col_cnt     = 0;
  int unsigned row_cnt     = 0;
  int unsigned face_x      = 0;
  int unsigned face_y      = 0;
  int unsigned face_w      = 1;
  int unsigned face_h      = 1;

  // Texels still owed by the block, oldest first.
  texel_t texel_q [$];
  directed_row_t directed_rows [$];

  // What the sender attaches to the word it is presenting right now.
  bit     word_typed;
  texel_t word_want;

  sample_t seen;
  texel_t  got;
  texel_t  owed;
  texel_t  predicted;

  int          cycles         = 0;
  int          mismatches     = 0;
  int          words_in       = 0;
  int          faces_started  = 0;
  int          texels_checked = 0;
  int          reg_writes     = 0;
  int          burst_left     = 0;
  int          stall_left     = 0;
  ready_mode_t stall_mode     = READY_ALWAYS;
  logic [31:0] stall_pattern  = '1;

  int unsigned atlas_w_set [NUM_PHASES] = '{2048, 4095, 0, 1, 0, 17, 16};
  int unsigned atlas_h_set [NUM_PHASES] = '{2048, 4095, 0, 4095, 0, 2047, 16};

  // The clock runs from time zero; everything else is driven from the
  // falling edge so the block sees stable inputs at each rising edge.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Saturate a side to the largest atlas side, and raise it to a floor.
  function automatic int unsigned clamp_side(int unsigned v, int unsigned floor_v);
    if (v < floor_v) return floor_v;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  // Shift one mantissa by the shared exponent, saturating at 255. Shifts of
  // eight or more either way collapse to full scale or to zero.
  function automatic int unsigned shift_mantissa(rlab_pkg::color_t m, rlab_pkg::expo_t e);
    int ei;
    int unsigned v;
    ei = e;
    if (ei >= 0) begin
      if (m == 0) return 0;
      if (ei >= 8) return 255;
      v = int'(m) << ei;
      return (v > 255) ? 255 : v;
    end
    if (ei <= -8) return 0;
    return int'(m) >> (-ei);
  endfunction

  // Work out the texel of one accepted sample word and step the face walk.
  function automatic texel_t blit_sample(sample_t s);
    texel_t      t;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned aw;
    int unsigned ah;
    if (s.face_start) begin
      face_x  = s.origin_x;
      face_y  = s.origin_y;
      face_w  = clamp_side(s.face_width, 1);
      face_h  = clamp_side(s.face_height, 1);
      col_cnt = 0;
      row_cnt = 0;
    end
    r = shift_mantissa(s.red, s.exponent);
    g = shift_mantissa(s.green, s.exponent);
    b = shift_mantissa(s.blue, s.exponent);
    t.pixel = {r[7:3], g[7:2], b[7:3]};
    aw = clamp_side(atlas_w_reg, 0);
    ah = clamp_side(atlas_h_reg, 0);
    t.address       = rlab_pkg::addr_t'((face_x + col_cnt) + (face_y + row_cnt) * aw);
    t.last_of_face  = (col_cnt + 1 == face_w) && (row_cnt + 1 == face_h);
    t.out_of_bounds = (face_x + face_w > aw) || (face_y + face_h > ah);
    // After the last sample the walk wraps back to the face origin.
    col_cnt++;
    if (col_cnt >= face_w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= face_h) row_cnt = 0;
    end
    return t;
  endfunction

  function automatic void add_row(int r, int g, int b, int e, bit fs, int ox, int oy,
                                  int fw, int fh, bit typed, int addr, int pix,
                                  bit last, bit oob);
    directed_row_t row;
    row.smp.red                = rlab_pkg::color_t'(r);
    row.smp.green              = rlab_pkg::color_t'(g);
    row.smp.blue               = rlab_pkg::color_t'(b);
    row.smp.exponent           = rlab_pkg::expo_t'(e);
    row.smp.face_start         = fs;
    row.smp.origin_x           = rlab_pkg::origin_t'(ox);
    row.smp.origin_y           = rlab_pkg::origin_t'(oy);
    row.smp.face_width         = rlab_pkg::side_t'(fw);
    row.smp.face_height        = rlab_pkg::side_t'(fh);
    row.typed                  = typed;
    row.want.address           = rlab_pkg::addr_t'(addr);
    row.want.pixel             = rlab_pkg::pixel_t'(pix);
    row.want.last_of_face      = last;
    row.want.out_of_bounds     = oob;
    directed_rows.push_back(row);
  endfunction

  // A sample with random colors and placement. Most exponents sit near the
  // saturation thresholds; the rest cover the whole signed range.
  function automatic sample_t rand_sample(bit fs);
    sample_t s;
    s.red         = rlab_pkg::color_t'($urandom);
    s.green       = rlab_pkg::color_t'($urandom);
    s.blue        = rlab_pkg::color_t'($urandom);
    if ($urandom_range(0, 2) != 0)
      s.exponent = rlab_pkg::expo_t'(int'($urandom_range(0, 20)) - 10);
    else s.exponent = rlab_pkg::expo_t'($urandom);
    s.face_start  = fs;
    s.origin_x    = rlab_pkg::origin_t'($urandom);
    s.origin_y    = rlab_pkg::origin_t'($urandom);
    s.face_width  = rlab_pkg::side_t'($urandom);
    s.face_height = rlab_pkg::side_t'($urandom);
    return s;
  endfunction

  task automatic report_mismatch(bit had_want, texel_t w, texel_t a);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      if (had_want)
        $display("%0t: texel mismatch: expected addr %h pixel %h last %b oob %b, got addr %h pixel %h last %b oob %b",
                 $realtime, w.address, w.pixel, w.last_of_face, w.out_of_bounds,
                 a.address, a.pixel, a.last_of_face, a.out_of_bounds);
      else
        $display("%0t: texel with nothing owed: addr %h pixel %h last %b oob %b",
                 $realtime, a.address, a.pixel, a.last_of_face, a.out_of_bounds);
    end
  endtask

  // Present one sample word and hold it until the block takes it. The sender
  // works in bursts; when a burst runs out, valid drops for a random gap.
  task automatic send_word(sample_t s, bit typed, texel_t want);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.red         = s.red;
    in_ch.green       = s.green;
    in_ch.blue        = s.blue;
    in_ch.exponent    = s.exponent;
    in_ch.face_start  = s.face_start;
    in_ch.origin_x    = s.origin_x;
    in_ch.origin_y    = s.origin_y;
    in_ch.face_width  = s.face_width;
    in_ch.face_height = s.face_height;
    word_typed        = typed;
    word_want         = want;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Let the block run dry: every owed texel back, then the pipeline margin.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (texel_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Program both atlas registers back to back while the block is idle. Valid
  // stays high across the two words and drops once after the second.
  task automatic program_atlas(int unsigned w, int unsigned h);
    settle();
    cfg_ch.index = rlab_pkg::CFG_ATLAS_WIDTH;
    cfg_ch.data  = rlab_pkg::cfg_data_t'(w);
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.index = rlab_pkg::CFG_ATLAS_HEIGHT;
    cfg_ch.data  = rlab_pkg::cfg_data_t'(h);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Watch all three channels at the rising edge. The configuration shadow is
  // only touched while no sample word is in flight, so the order of the
  // three checks below does not matter.
  always @(posedge clk) begin
    cycles++;
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      reg_writes++;
      case (cfg_ch.index)
        rlab_pkg::CFG_ATLAS_WIDTH:  atlas_w_reg = cfg_ch.data;
        rlab_pkg::CFG_ATLAS_HEIGHT: atlas_h_reg = cfg_ch.data;
        default: ;
      endcase
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.red         = in_ch.red;
      seen.green       = in_ch.green;
      seen.blue        = in_ch.blue;
      seen.exponent    = in_ch.exponent;
      seen.face_start  = in_ch.face_start;
      seen.origin_x    = in_ch.origin_x;
      seen.origin_y    = in_ch.origin_y;
      seen.face_width  = in_ch.face_width;
      seen.face_height = in_ch.face_height;
      // The predictor always runs so the face walk stays in step, even when
      // the directed row supplies its own texel.
      predicted = blit_sample(seen);
      texel_q.push_back(word_typed ? word_want : predicted);
      words_in++;
      if (seen.face_start) faces_started++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.address       = out_ch.address;
      got.pixel         = out_ch.pixel;
      got.last_of_face  = out_ch.last_of_face;
      got.out_of_bounds = out_ch.out_of_bounds;
      if (texel_q.size() == 0) begin
        report_mismatch(1'b0, got, got);
      end else begin
        owed = texel_q.pop_front();
        texels_checked++;
        if (got.address !== owed.address || got.pixel !== owed.pixel ||
            got.last_of_face !== owed.last_of_face ||
            got.out_of_bounds !== owed.out_of_bounds)
          report_mismatch(1'b1, owed, got);
      end
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d texels still owed", cycles, texel_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The texel receiver switches between ready patterns at random intervals:
  // always ready, coin flips, a rotating bit pattern, and long stalls.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_mode    = ready_mode_t'($urandom_range(0, 3));
        stall_left    = $urandom_range(20, 80);
        stall_pattern = $urandom;
      end
      stall_left--;
      stall_pattern = {stall_pattern[30:0], stall_pattern[31]};
      case (stall_mode)
        READY_ALWAYS:  out_ch.ready = 1'b1;
        READY_COIN:    out_ch.ready = 1'($urandom_range(0, 1));
        READY_PATTERN: out_ch.ready = stall_pattern[0];
        default:       out_ch.ready = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    sample_t     s;
    texel_t      none;
    int unsigned fw;
    int unsigned fh;
    int          walk_len;
    int          pick;
    int          phase_base;

    none = '{default: '0};
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.red          = '0;
    in_ch.green        = '0;
    in_ch.blue         = '0;
    in_ch.exponent     = '0;
    in_ch.face_start   = 1'b0;
    in_ch.origin_x     = '0;
    in_ch.origin_y     = '0;
    in_ch.face_width   = '0;
    in_ch.face_height  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = rlab_pkg::CFG_ATLAS_WIDTH;
    cfg_ch.data        = '0;
    word_typed         = 1'b0;
    word_want          = none;

    // Directed words. Before any face starts, every sample sits on the reset
    // face of one texel at the origin, so each is last of its face.
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 16'h0000, 1, 0);
    add_row(255, 255, 255, 0, 0, 0, 0, 0, 0, 1, 0, 16'hFFFF, 1, 0);
    // A large left shift saturates nonzero mantissas; zero stays zero.
    add_row(1, 0, 128, 8, 0, 0, 0, 0, 0, 1, 0, 16'hF81F, 1, 0);
    add_row(0, 255, 0, 127, 0, 0, 0, 0, 0, 1, 0, 16'h07E0, 1, 0);
    // A large right shift clears everything.
    add_row(255, 255, 255, -8, 0, 0, 0, 0, 0, 1, 0, 16'h0000, 1, 0);
    add_row(255, 255, 255, -128, 0, 0, 0, 0, 0, 1, 0, 16'h0000, 1, 0);
    add_row(255, 255, 255, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 2, 37, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(200, 100, 50, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // A zero face size counts as one.
    add_row(0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 16'h0000, 1, 0);
    // A one-texel face in the far corner of the 16 by 16 atlas still fits.
    add_row(0, 0, 0, 0, 1, 15, 15, 1, 1, 1, 255, 16'h0000, 1, 0);
    // Two wide from the last column spills over; the walk then wraps back.
    add_row(0, 0, 0, 0, 1, 15, 15, 2, 1, 1, 255, 16'h0000, 0, 1);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 256, 16'h0000, 1, 1);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 255, 16'h0000, 0, 1);
    // Oversize faces saturate at the largest side and land out of bounds.
    add_row(0, 0, 0, 0, 1, 2047, 2047, 4095, 4095, 1, 34799, 16'h0000, 0, 1);
    add_row(0, 0, 0, 0, 1, 0, 0, 2049, 1, 1, 0, 16'h0000, 0, 1);
    // A face that fills the atlas exactly is in bounds.
    add_row(0, 0, 0, 0, 1, 0, 0, 16, 16, 1, 0, 16'h0000, 0, 0);
    add_row($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 2,
            0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // A full three by two face walk with arbitrary colors.
    add_row($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 1,
            1, 1, 2, 3, 2, 0, 0, 0, 0, 0);
    repeat (5)
      add_row($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              int'($urandom_range(0, 6)) - 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);

    // Random phases, each under its own atlas setting. One setting is drawn
    // at random; the others cover the extremes, including a zero-sized atlas
    // and register values past the largest side.
    atlas_w_set[4] = $urandom_range(16, MAX_SIDE);
    atlas_h_set[4] = $urandom_range(16, MAX_SIDE);
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_atlas(atlas_w_set[p], atlas_h_set[p]);
      phase_base = words_in;
      while (words_in - phase_base < WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          // Well-formed face: a start word, then the rest of its walk.
          s  = rand_sample(1'b1);
          fw = $urandom_range(1, 8);
          fh = $urandom_range(1, 6);
          case ($urandom_range(0, 9))
            0: fw = 0;
            1: fh = 0;
            2: fw = $urandom_range(MAX_SIDE, 4095);
            3: fh = $urandom_range(MAX_SIDE, 4095);
            default: ;
          endcase
          s.face_width  = rlab_pkg::side_t'(fw);
          s.face_height = rlab_pkg::side_t'(fh);
          if ($urandom_range(0, 3) != 0) begin
            s.origin_x = rlab_pkg::origin_t'($urandom_range(0, 20));
            s.origin_y = rlab_pkg::origin_t'($urandom_range(0, 20));
          end
          walk_len = clamp_side(fw, 1) * clamp_side(fh, 1);
          if (walk_len > 48) walk_len = $urandom_range(2, 8);
          // Some faces are cut short by the next start, some run past the end.
          case ($urandom_range(0, 9))
            0: walk_len = $urandom_range(1, walk_len);
            1: walk_len = walk_len + $urandom_range(1, 4);
            default: ;
          endcase
          send_word(s, 1'b0, none);
          for (int k = 1; k < walk_len; k++) send_word(rand_sample(1'b0), 1'b0, none);
        end else begin
          // Noise: a lone word with every field random.
          send_word(rand_sample(1'($urandom_range(0, 1))), 1'b0, none);
        end
      end
    end

    settle();
    $display("Covered %0d sample words over %0d face starts and %0d register writes.",
             words_in, faces_started, reg_writes);
    $display("Checked %0d texels across %0d atlas settings; %0d mismatches.",
             texels_checked, NUM_PHASES + 1, mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
